@@ design/text_console_cursor_scroll_defines.svh @@
// Assertion helpers shared by the console engine.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TCCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCCS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/tccs_pkg.sv @@
package tccs_pkg;

   localparam int SCREEN_CELLS_DEF = 8192;
   localparam int MAX_COLUMNS_DEF  = 128;

   localparam logic [2:0] CMD_PUT    = 3'd0;
   localparam logic [2:0] CMD_SET    = 3'd1;
   localparam logic [2:0] CMD_SCROLL = 3'd2;
   localparam logic [2:0] CMD_FILL   = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_WIDTH    = 3'd2;
   localparam logic [2:0] REG_HEIGHT   = 3'd3;
   localparam logic [2:0] REG_STRIDE   = 3'd4;
   localparam logic [2:0] REG_ATTR     = 3'd5;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUT,
      ST_SETC,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_FILL,
      ST_READ_RD,
      ST_READ_WR,
      ST_DONE
   } state_type;

endpackage

@@ design/tccs_ram.sv @@
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/text_console_cursor_scroll.sv @@
// Text console engine: character and color stores, cursor, region scroll.
// Command items enter on req_ (tuser = command, tdata = operands); every
// item yields exactly one result item on rsp_ carrying the cursor and, for
// a cell read, the cell's character and color. Region registers are written
// on the csr_ port; the user must write them only while no command is in
// flight, which the block does not enforce. One item is processed at a time;
// req_tready is high only while idle, and the next item is taken the cycle
// after the previous result is loaded. Put writes the cell, then moves the
// cursor; read fetches the cell, then captures it; fill writes the region
// cell by cell. Put or set cursor that runs past the bottom row adds a scroll
// walk. Scroll first copies the region into a snapshot RAM (read then write
// for each cell), then rebuilds the region from it (read then write for each
// cell); every address goes through one shared row-times-stride multiplier.
// SCREEN_CELLS must be a power of two; addresses wrap modulo it.
// Reset returns the cursor to zero and the region registers to their
// defaults; the stores are left as they are. A result held by a stalled
// receiver stays in the output register; the next item may be accepted
// meanwhile, and its own result waits until that register is free.
module text_console_cursor_scroll #(
   parameter int SCREEN_CELLS = tccs_pkg::SCREEN_CELLS_DEF,
   parameter int MAX_COLUMNS  = tccs_pkg::MAX_COLUMNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[7:0], pos_x[16:8], pos_y[25:17], scroll_cols[33:26],
   // scroll_rows[41:34], zero fill
   input  logic [47:0] req_tdata,
   // command[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_col[6:0], cursor_row[13:7], cursor_position_word[45:14],
   // cell_char[53:46], cell_attribute[61:54], zero fill
   output logic [63:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import tccs_pkg::*;
   `include "text_console_cursor_scroll_defines.svh"

   localparam int AW      = $clog2(SCREEN_CELLS);
   localparam int COL_LIM = (MAX_COLUMNS < 128) ? MAX_COLUMNS : 128;

   state_type state_ff, state_in;

   logic [6:0] ox_ff, oy_ff;
   logic [7:0] rw_ff, rh_ff, stride_ff, attr_ff;
   logic [6:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [6:0] cnx_ff, cnx_in, cny_ff, cny_in;
   logic       upd_ff, upd_in;
   logic [7:0] ch_ff, ch_in;
   logic signed [10:0] px_ff, px_in, py_ff, py_in;
   logic signed [10:0] sh_ff, sh_in, sv_ff, sv_in;
   logic [6:0] wx_ff, wx_in, wy_ff, wy_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic       inr_ff, inr_in;
   logic [7:0] rch_ff, rch_in, rat_ff, rat_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic [7:0] eff_w, eff_h;
   logic       walk_last;
   logic signed [11:0] ax, ay, sx, sy;
   logic signed [12:0] ry;
   logic signed [21:0] prod;
   logic signed [22:0] lin;
   logic [AW-1:0] cell_addr;
   logic       src_in_range;
   logic       accept, out_free;

   logic          st_we, sn_we;
   logic [AW-1:0] st_waddr, st_raddr, sn_waddr, sn_raddr;
   logic [15:0]   st_wdata, st_rdata, sn_wdata, sn_rdata;

   // Region size as used: width 1..COL_LIM, height 1..128.
   always_comb begin
      if (rw_ff == 8'd0) begin
         eff_w = 8'd1;
      end else if ({1'b0, rw_ff} > 9'(COL_LIM)) begin
         eff_w = 8'(COL_LIM);
      end else begin
         eff_w = rw_ff;
      end
      if (rh_ff == 8'd0) begin
         eff_h = 8'd1;
      end else if (rh_ff > 8'd128) begin
         eff_h = 8'd128;
      end else begin
         eff_h = rh_ff;
      end
   end

   assign walk_last = ({1'b0, wx_ff} == eff_w - 8'd1) && ({1'b0, wy_ff} == eff_h - 8'd1);
   assign sx = $signed({5'b0, wx_ff}) + 12'(sh_ff);
   assign sy = $signed({5'b0, wy_ff}) + 12'(sv_ff);
   assign src_in_range = (sx >= 12'sd0) && (sx < $signed({4'b0, eff_w}))
                      && (sy >= 12'sd0) && (sy < $signed({4'b0, eff_h}));

   // Shared address unit: (origin_y + y) * stride + origin_x + x.
   always_comb begin
      unique case (state_ff)
         ST_PUT: begin
            ax = $signed({5'b0, cx_ff});
            ay = $signed({5'b0, cy_ff});
         end
         ST_READ_RD: begin
            ax = 12'(px_ff);
            ay = 12'(py_ff);
         end
         ST_MOVE_RD: begin
            ax = sx;
            ay = sy;
         end
         default: begin
            ax = $signed({5'b0, wx_ff});
            ay = $signed({5'b0, wy_ff});
         end
      endcase
   end

   assign ry        = $signed({6'b0, oy_ff}) + 13'(ay);
   assign prod      = ry * $signed({1'b0, stride_ff});
   assign lin       = 23'(prod) + $signed({16'b0, ox_ff}) + 23'(ax);
   assign cell_addr = lin[AW-1:0];

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  CMD_PUT:    state_in = ST_PUT;
                  CMD_SET:    state_in = ST_SETC;
                  CMD_SCROLL: state_in = ST_COPY_RD;
                  CMD_FILL:   state_in = ST_FILL;
                  CMD_READ:   state_in = ST_READ_RD;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_PUT:     state_in = ST_SETC;
         ST_SETC: begin
            if (py_in >= $signed({3'b0, eff_h})) begin
               state_in = ST_COPY_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: state_in = walk_last ? ST_MOVE_RD : ST_COPY_RD;
         ST_MOVE_RD: state_in = ST_MOVE_WR;
         ST_MOVE_WR: state_in = walk_last ? ST_DONE : ST_MOVE_RD;
         ST_FILL:    state_in = walk_last ? ST_DONE : ST_FILL;
         ST_READ_RD: state_in = ST_READ_WR;
         ST_READ_WR: state_in = ST_DONE;
         ST_DONE:    state_in = out_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      logic signed [10:0] nx, ny;
      logic [6:0]         fcx, fcy;
      logic [7:0]         pos_r, pos_c;

      cx_in = cx_ff;   cy_in = cy_ff;
      cnx_in = cnx_ff; cny_in = cny_ff; upd_in = upd_ff;
      ch_in = ch_ff;   px_in = px_ff;   py_in = py_ff;
      sh_in = sh_ff;   sv_in = sv_ff;
      wx_in = wx_ff;   wy_in = wy_ff;
      addr_in = addr_ff; inr_in = inr_ff;
      rch_in = rch_ff; rat_in = rat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      st_we = 1'b0; st_waddr = cell_addr; st_wdata = {attr_ff, ch_ff};
      st_raddr = cell_addr;
      sn_we = 1'b0; sn_waddr = addr_ff; sn_wdata = st_rdata;
      sn_raddr = cell_addr;
      nx = px_ff; ny = py_ff;
      fcx = cx_ff; fcy = cy_ff; pos_r = 8'd0; pos_c = 8'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in  = req_tdata[7:0];
               px_in  = 11'($signed(req_tdata[16:8]));
               py_in  = 11'($signed(req_tdata[25:17]));
               sh_in  = 11'($signed(req_tdata[33:26]));
               sv_in  = 11'($signed(req_tdata[41:34]));
               wx_in  = 7'd0;
               wy_in  = 7'd0;
               upd_in = 1'b0;
               rch_in = 8'd0;
               rat_in = 8'd0;
            end
         end
         ST_PUT: begin
            st_we = 1'b1;
            px_in = $signed({4'b0, cx_ff}) + 11'sd1;
            py_in = $signed({4'b0, cy_ff});
         end
         ST_SETC: begin
            // Wrap past the right edge, clamp negatives, scroll past the bottom.
            if (nx < 11'sd0) begin
               nx = 11'sd0;
            end else if (nx >= $signed({3'b0, eff_w})) begin
               nx = 11'sd0;
               ny = ny + 11'sd1;
            end
            if (ny < 11'sd0) begin
               ny = 11'sd0;
            end
            py_in  = ny;
            upd_in = 1'b1;
            cnx_in = nx[6:0];
            if (ny >= $signed({3'b0, eff_h})) begin
               sh_in  = 11'sd0;
               sv_in  = ny - $signed({3'b0, eff_h}) + 11'sd1;
               cny_in = 7'(eff_h - 8'd1);
               wx_in  = 7'd0;
               wy_in  = 7'd0;
            end else begin
               cny_in = ny[6:0];
            end
         end
         ST_COPY_RD: begin
            addr_in = cell_addr;
         end
         ST_COPY_WR: begin
            sn_we = 1'b1;
            if (walk_last) begin
               wx_in = 7'd0;
               wy_in = 7'd0;
            end else if ({1'b0, wx_ff} == eff_w - 8'd1) begin
               wx_in = 7'd0;
               wy_in = wy_ff + 7'd1;
            end else begin
               wx_in = wx_ff + 7'd1;
            end
         end
         ST_MOVE_RD: begin
            inr_in = src_in_range;
         end
         ST_MOVE_WR, ST_FILL: begin
            st_we = 1'b1;
            if (state_ff == ST_MOVE_WR) begin
               st_wdata = inr_ff ? sn_rdata : {attr_ff, SPACE_CHAR};
            end
            if ({1'b0, wx_ff} == eff_w - 8'd1) begin
               wx_in = 7'd0;
               wy_in = wy_ff + 7'd1;
            end else begin
               wx_in = wx_ff + 7'd1;
            end
         end
         ST_READ_RD: begin
         end
         ST_READ_WR: begin
            rch_in = st_rdata[7:0];
            rat_in = st_rdata[15:8];
         end
         ST_DONE: begin
            if (out_free) begin
               fcx = upd_ff ? cnx_ff : cx_ff;
               fcy = upd_ff ? cny_ff : cy_ff;
               cx_in = fcx;
               cy_in = fcy;
               pos_r = {1'b0, oy_ff} + {1'b0, fcy};
               pos_c = {1'b0, ox_ff} + {1'b0, fcx};
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b0, rat_ff, rch_ff, 8'b0, pos_r, 8'b0, pos_c, fcy, fcx};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cx_ff        <= 7'd0;
         cy_ff        <= 7'd0;
         ox_ff        <= 7'd0;
         oy_ff        <= 7'd0;
         rw_ff        <= 8'd96;
         rh_ff        <= 8'd71;
         stride_ff    <= 8'd100;
         attr_ff      <= 8'd116;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         if (csr_we) begin
            case (csr_index)
               REG_ORIGIN_X: ox_ff     <= csr_wdata[6:0];
               REG_ORIGIN_Y: oy_ff     <= csr_wdata[6:0];
               REG_WIDTH:    rw_ff     <= csr_wdata;
               REG_HEIGHT:   rh_ff     <= csr_wdata;
               REG_STRIDE:   stride_ff <= csr_wdata;
               REG_ATTR:     attr_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnx_ff      <= cnx_in;
      cny_ff      <= cny_in;
      upd_ff      <= upd_in;
      ch_ff       <= ch_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      sh_ff       <= sh_in;
      sv_ff       <= sv_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      addr_ff     <= addr_in;
      inr_ff      <= inr_in;
      rch_ff      <= rch_in;
      rat_ff      <= rat_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Character in the low byte, color in the high byte.
   tccs_ram #(.WIDTH(16), .DEPTH(SCREEN_CELLS)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   tccs_ram #(.WIDTH(16), .DEPTH(SCREEN_CELLS)) u_snap (
      .clock (clock),
      .we    (sn_we),
      .waddr (sn_waddr),
      .wdata (sn_wdata),
      .raddr (sn_raddr),
      .rdata (sn_rdata)
   );

   `TCCS_ASSERT(a_busy_not_ready, (state_ff != ST_IDLE) |-> !req_tready, "ready while busy")
   `TCCS_ASSERT(a_copy_no_store_write, (state_ff == ST_COPY_RD || state_ff == ST_COPY_WR) |-> !st_we, "store written during snapshot copy")
   `TCCS_ASSERT(a_walk_in_region, (state_ff == ST_FILL || state_ff == ST_MOVE_WR || state_ff == ST_COPY_WR) |-> ({1'b0, wx_ff} < eff_w && {1'b0, wy_ff} < eff_h), "walk outside region")
   `TCCS_ASSERT_ALWAYS(a_single_write, !(st_we && sn_we), "both stores written at once")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import tccs_pkg::*;

   localparam int CELLS = 8192;

   typedef struct {
      bit [6:0]  col;
      bit [6:0]  row;
      bit [31:0] word;
      bit [7:0]  ch;
      bit [7:0]  attr;
   } cursor_cell_type;

   class console_scoreboard;
      bit [7:0] chars [CELLS];
      bit [7:0] colors [CELLS];
      bit [7:0] snap_c [CELLS];
      bit [7:0] snap_a [CELLS];
      bit       written [CELLS];
      bit [6:0] cur_x, cur_y;
      bit [6:0] org_x, org_y;
      bit [7:0] reg_w, reg_h, stride, attr;
      cursor_cell_type expected_q [$];
      int errors;

      function new();
         cur_x = 0; cur_y = 0; org_x = 0; org_y = 0;
         reg_w = 96; reg_h = 71; stride = 100; attr = 116;
         errors = 0;
      endfunction

      function void write_reg(bit [2:0] idx, bit [7:0] val);
         case (idx)
            REG_ORIGIN_X: org_x = val[6:0];
            REG_ORIGIN_Y: org_y = val[6:0];
            REG_WIDTH:    reg_w = val;
            REG_HEIGHT:   reg_h = val;
            REG_STRIDE:   stride = val;
            REG_ATTR:     attr = val;
            default: ;
         endcase
      endfunction

      function int eff_w();
         return (reg_w < 1) ? 1 : (reg_w > 128) ? 128 : reg_w;
      endfunction

      function int eff_h();
         return (reg_h < 1) ? 1 : (reg_h > 128) ? 128 : reg_h;
      endfunction

      function int cell_index(int x, int y);
         int a;
         a = (int'(org_y) + y) * int'(stride) + int'(org_x) + x;
         a = a % CELLS;
         if (a < 0) a += CELLS;
         return a;
      endfunction

      function void store(int a, bit [7:0] c);
         chars[a] = c;
         colors[a] = attr;
         written[a] = 1;
      endfunction

      function void scroll_region(int h, int v);
         int w, ht, sx, sy, d, s;
         w = eff_w();
         ht = eff_h();
         snap_c = chars;
         snap_a = colors;
         for (int y = 0; y < ht; y++)
            for (int x = 0; x < w; x++) begin
               sx = x + h;
               sy = y + v;
               d = cell_index(x, y);
               if (sx >= 0 && sx < w && sy >= 0 && sy < ht) begin
                  s = cell_index(sx, sy);
                  chars[d] = snap_c[s];
                  colors[d] = snap_a[s];
                  written[d] = 1;
               end else begin
                  store(d, SPACE_CHAR);
               end
            end
      endfunction

      function void place_cursor(int x, int y);
         if (x < 0) x = 0;
         else if (x >= eff_w()) begin
            x = 0;
            y++;
         end
         if (y < 0) y = 0;
         else if (y >= eff_h()) begin
            scroll_region(0, y - eff_h() + 1);
            y = eff_h() - 1;
         end
         cur_x = x[6:0];
         cur_y = y[6:0];
      endfunction

      function void note_command(bit [2:0] cmd, bit [47:0] d);
         cursor_cell_type e;
         int px, py, a;
         px = int'($signed(d[16:8]));
         py = int'($signed(d[25:17]));
         e.ch = 0;
         e.attr = 0;
         case (cmd)
            CMD_PUT: begin
               store(cell_index(cur_x, cur_y), d[7:0]);
               place_cursor(int'(cur_x) + 1, cur_y);
            end
            CMD_SET:    place_cursor(px, py);
            CMD_SCROLL: scroll_region(int'($signed(d[33:26])), int'($signed(d[41:34])));
            CMD_FILL: begin
               for (int y = 0; y < eff_h(); y++)
                  for (int x = 0; x < eff_w(); x++) store(cell_index(x, y), d[7:0]);
            end
            CMD_READ: begin
               a = cell_index(px, py);
               e.ch = chars[a];
               e.attr = colors[a];
            end
            default: ;
         endcase
         e.col = cur_x;
         e.row = cur_y;
         e.word = {(16'(org_y) + 16'(cur_y)), (16'(org_x) + 16'(cur_x))};
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_result(bit [63:0] r);
         cursor_cell_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result %h", r));
            return;
         end
         e = expected_q.pop_front();
         if (r[6:0] != e.col) report($sformatf("col %0d exp %0d", r[6:0], e.col));
         if (r[13:7] != e.row) report($sformatf("row %0d exp %0d", r[13:7], e.row));
         if (r[45:14] != e.word) report($sformatf("pos word %h exp %h", r[45:14], e.word));
         if (r[53:46] != e.ch) report($sformatf("char %h exp %h", r[53:46], e.ch));
         if (r[61:54] != e.attr) report($sformatf("attr %h exp %h", r[61:54], e.attr));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   bit idle_on = 1;
   console_scoreboard sb = new();

   text_console_cursor_scroll uut (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #400_000_000;
      $display("text_console_cursor_scroll verification failed");
      $finish;
   end

   // result side: random backpressure while idle_on is set, check every accepted item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      rsp_tready <= !idle_on || ($urandom_range(99) >= 31);
   end

   task send_command(bit [2:0] cmd, bit [47:0] d);
      if (idle_on && $urandom_range(99) < 31) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, d);
   endtask

   task pack_send(bit [2:0] cmd, bit [7:0] ch, int px, int py, int sc, int sr);
      send_command(cmd, {6'b0, 8'(sr), 8'(sc), 9'(py), 9'(px), ch});
   endtask

   task drain();
      req_tvalid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // leave the write enable high; the caller drops it after the last write
   task write_csr(bit [2:0] idx, bit [7:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task random_command();
      bit [47:0] d;
      int pick, px, py;
      d = {6'b0, 32'($urandom), 10'($urandom)};
      pick = $urandom_range(99);
      if (pick < 45) send_command(CMD_PUT, d);
      else if (pick < 58) begin
         // keep most cursor moves inside or just past the region
         if ($urandom_range(3) != 0) begin
            d[16:8] = 9'($urandom_range(0, sb.eff_w()));
            d[25:17] = 9'($urandom_range(0, sb.eff_h()));
         end
         send_command(CMD_SET, d);
      end else if (pick < 65) begin
         if ($urandom_range(2) != 0) begin
            d[33:26] = 8'($urandom_range(0, 6) - 3);
            d[41:34] = 8'($urandom_range(0, 6) - 3);
         end
         send_command(CMD_SCROLL, d);
      end else if (pick < 68) send_command(CMD_FILL, d);
      else if (pick < 95) begin
         // prefer cells that hold something, else read a cell inside the region
         px = int'($signed(d[16:8]));
         py = int'($signed(d[25:17]));
         if (!sb.written[sb.cell_index(px, py)]) begin
            px = $urandom_range(0, sb.eff_w() - 1);
            py = $urandom_range(0, sb.eff_h() - 1);
         end
         pack_send(CMD_READ, d[7:0], px, py, 0, 0);
      end else send_command(3'($urandom_range(5, 7)), d);
   endtask

   task configure(bit [6:0] ox, bit [6:0] oy, bit [7:0] w, bit [7:0] h, bit [7:0] st,
                  bit [7:0] at);
      write_csr(REG_ORIGIN_X, ox);
      write_csr(REG_ORIGIN_Y, oy);
      write_csr(REG_WIDTH, w);
      write_csr(REG_HEIGHT, h);
      write_csr(REG_STRIDE, st);
      write_csr(REG_ATTR, at);
      csr_we <= 0;
   endtask

   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset region
      pack_send(CMD_FILL, 8'hff, 0, 0, 0, 0);
      pack_send(CMD_PUT, 8'h00, 0, 0, 0, 0);
      pack_send(CMD_PUT, 8'hff, 0, 0, 0, 0);
      pack_send(CMD_READ, 8'h00, 0, 0, 0, 0);
      pack_send(CMD_READ, 8'h00, 1, 0, 0, 0);
      pack_send(CMD_SET, 8'h00, -256, -256, 0, 0);
      pack_send(CMD_SET, 8'h00, 95, 70, 0, 0);
      pack_send(CMD_PUT, 8'h41, 0, 0, 0, 0);
      pack_send(CMD_SET, 8'h00, 255, 255, 0, 0);
      pack_send(CMD_SET, 8'h00, 96, 10, 0, 0);
      pack_send(CMD_SCROLL, 8'h00, 0, 0, 1, -1);
      pack_send(CMD_SCROLL, 8'h00, 0, 0, -3, 2);
      pack_send(CMD_READ, 8'h00, 95, 70, 0, 0);
      pack_send(CMD_SCROLL, 8'h00, 0, 0, 127, 127);
      pack_send(CMD_SCROLL, 8'h00, 0, 0, -128, -128);
      pack_send(CMD_READ, 8'h00, 0, 0, 0, 0);
      pack_send(3'd5, 8'h00, 0, 0, 0, 0);
      pack_send(3'd6, 8'h00, 0, 0, 0, 0);
      pack_send(3'd7, 8'hff, 255, 255, 127, -128);
      drain();

      for (int p = 0; p < 13; p++) begin
         n = 150;
         if (p == 0) begin
            configure(7'd127, 7'd127, 8'd128, 8'd128, 8'd255, 8'hff);
            n = 6;
         end else if (p == 1) begin
            configure(7'd0, 7'd0, 8'd0, 8'd0, 8'd0, 8'h00);
         end else if (p == 2) begin
            configure(7'd3, 7'd5, 8'd200, 8'd1, 8'd128, 8'h5a);
            n = 6;
         end else begin
            configure(7'($urandom), 7'($urandom), 8'($urandom_range(1, 16)),
                      8'($urandom_range(1, 12)),
                      ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 128)),
                      8'($urandom));
            n = 175;
         end
         idle_on = (p != 4);
         pack_send(CMD_FILL, 8'($urandom), 0, 0, 0, 0);
         for (int i = 0; i < n; i++) begin
            if (p == 5 && i == n / 2) drain();
            random_command();
         end
         drain();
      end

      idle_on = 1;
      drain();
      if (sb.errors == 0) $display("text_console_cursor_scroll verification clean");
      else $display("text_console_cursor_scroll verification failed");
      $finish;
   end
endmodule
